>>> sv/stdc_pkg.sv
package stdc_pkg;

  localparam int DEPTH   = 131072;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int NUM_W   = 40;
  localparam int LEN_W   = 18;
  localparam int PRIME_W = 20;
  localparam int DVS_W   = 20;
  localparam int IDX_W   = ((LEN_W > PRIME_W) ? LEN_W : PRIME_W) + 1;
  localparam int STEP_W  = $clog2(NUM_W + 1);

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_SIEVE  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam logic [2:0] SEL_LOW_P = 3'd0;
  localparam logic [2:0] SEL_R_P   = 3'd1;
  localparam logic [2:0] SEL_T_P   = 3'd2;
  localparam logic [2:0] SEL_T_R   = 3'd3;
  localparam logic [2:0] SEL_T_DVS = 3'd4;

  localparam logic [1:0] REG_LOW = 2'd0;
  localparam logic [1:0] REG_LEN = 2'd1;
  localparam logic [1:0] REG_DVS = 2'd2;

  typedef struct packed {
    logic       idx_clr;
    logic       cnt_clr;
    logic       p_load;
    logic       sq_load;
    logic       fill_wr;
    logic       div_go;
    logic [2:0] div_sel;
    logic       idx_from_rem;
    logic       idx_step_p;
    logic       idx_inc;
    logic       rt_load;
    logic       r_from_q;
    logic       t_sub_q;
    logic       sieve_wr;
    logic       fin_wr;
    logic       cnt_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic idx_last;
    logic sieve_ok;
    logic walk_end;
    logic walk_skip;
    logic div_done;
    logic rem_zero;
    logic r_zero;
    logic r_gt1;
    logic dvs_zero;
  } dp_stat_t;

endpackage

>>> sv/segmented_totient_divisible_count_core.sv
// Start writes each window entry (effective range_length) in turn, holding busy.
// Sieve divides range_low by the prime for the window offset, then steps over
// skipped slots and, per multiple, divides rest and totient in the shared divider.
// Finish visits each window entry, then gives the result beat on done.
// Throughput: one command at a time, taken once busy drops; the receiver cannot stall.
// Reset (rst, synchronous): registers to 1, controller idle; stores undefined.
module segmented_totient_divisible_count_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   command,
  input  logic [stdc_pkg::PRIME_W-1:0] prime_value,
  output logic                         done,
  output logic [stdc_pkg::LEN_W-1:0]   divisible_count,
  output logic [stdc_pkg::LEN_W-1:0]   window_count
);

  logic [stdc_pkg::NUM_W-1:0] range_low;
  logic [stdc_pkg::LEN_W-1:0] range_length;
  logic [stdc_pkg::DVS_W-1:0] divisor;
  logic                       wr;
  logic                       accept;
  stdc_pkg::dp_cmd_t          cmd;
  stdc_pkg::dp_stat_t         stat;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low    <= stdc_pkg::NUM_W'(1);
      range_length <= stdc_pkg::LEN_W'(1);
      divisor      <= stdc_pkg::DVS_W'(1);
    end else if (wr) begin
      case (paddr[4:3])
        stdc_pkg::REG_LOW: range_low    <= pwdata[stdc_pkg::NUM_W-1:0];
        stdc_pkg::REG_LEN: range_length <= pwdata[stdc_pkg::LEN_W-1:0];
        stdc_pkg::REG_DVS: divisor      <= pwdata[stdc_pkg::DVS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      stdc_pkg::REG_LOW: prdata = 64'(range_low);
      stdc_pkg::REG_LEN: prdata = 64'(range_length);
      stdc_pkg::REG_DVS: prdata = 64'(divisor);
      default:           prdata = '0;
    endcase
  end

  stdc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .command (command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  stdc_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .range_low       (range_low),
    .range_length    (range_length),
    .divisor         (divisor),
    .prime_value     (prime_value),
    .divisible_count (divisible_count),
    .window_count    (window_count)
  );

endmodule

>>> sv/stdc_div.sv
module stdc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [stdc_pkg::NUM_W-1:0] a,
  input  logic [stdc_pkg::NUM_W-1:0] b,
  output logic [stdc_pkg::NUM_W-1:0] quo,
  output logic [stdc_pkg::NUM_W-1:0] rem,
  output logic                       done
);

  logic                        active;
  logic [stdc_pkg::STEP_W-1:0] steps;
  logic [stdc_pkg::NUM_W:0]    part;
  logic [stdc_pkg::NUM_W-1:0]  q_sh;
  logic [stdc_pkg::NUM_W-1:0]  dvs;
  logic [stdc_pkg::NUM_W:0]    trial;
  logic                        fits;

  assign trial = {part[stdc_pkg::NUM_W-1:0], q_sh[stdc_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      steps  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        steps  <= stdc_pkg::STEP_W'(stdc_pkg::NUM_W);
      end else if (active) begin
        steps <= steps - 1'b1;
        if (steps == stdc_pkg::STEP_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      part <= '0;
      q_sh <= a;
      dvs  <= b;
    end else if (active) begin
      part <= fits ? (trial - {1'b0, dvs}) : trial;
      q_sh <= {q_sh[stdc_pkg::NUM_W-2:0], fits};
    end
  end

  assign quo = q_sh;
  assign rem = part[stdc_pkg::NUM_W-1:0];

endmodule

>>> sv/stdc_datapath.sv
module stdc_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  stdc_pkg::dp_cmd_t            cmd,
  output stdc_pkg::dp_stat_t           stat,
  input  logic [stdc_pkg::NUM_W-1:0]   range_low,
  input  logic [stdc_pkg::LEN_W-1:0]   range_length,
  input  logic [stdc_pkg::DVS_W-1:0]   divisor,
  input  logic [stdc_pkg::PRIME_W-1:0] prime_value,
  output logic [stdc_pkg::LEN_W-1:0]   divisible_count,
  output logic [stdc_pkg::LEN_W-1:0]   window_count
);

  localparam int NW = stdc_pkg::NUM_W;
  localparam int IW = stdc_pkg::IDX_W;
  localparam int PW = stdc_pkg::PRIME_W;
  localparam int LW = stdc_pkg::LEN_W;

  logic [NW-1:0] tot_mem  [stdc_pkg::DEPTH];
  logic [NW-1:0] rest_mem [stdc_pkg::DEPTH];
  logic [NW-1:0] tot_rd;
  logic [NW-1:0] rest_rd;

  logic [IW-1:0] idx;
  logic [LW-1:0] cnt;
  logic [PW-1:0] p;
  logic [NW-1:0] sq;
  logic [NW-1:0] r;
  logic [NW-1:0] t;

  logic [LW-1:0] len_eff;
  logic [NW:0]   top_sum;
  logic [NW-1:0] top;
  logic [NW:0]   n_sum;
  logic [NW-1:0] n_val;
  logic          p_pow2;
  logic [NW-1:0] div_a;
  logic [NW-1:0] div_b;
  logic [NW-1:0] div_q;
  logic [NW-1:0] div_r;
  logic          div_done;
  logic [stdc_pkg::ADDR_W-1:0] addr;
  logic          we;
  logic [NW-1:0] tot_wd;
  logic [NW-1:0] rest_wd;

  assign len_eff = (range_length > LW'(stdc_pkg::DEPTH)) ? LW'(stdc_pkg::DEPTH) : range_length;
  assign top_sum = {1'b0, range_low} + NW'(len_eff) - 1'b1;
  assign top     = top_sum[NW] ? '1 : top_sum[NW-1:0];
  assign n_sum   = {1'b0, range_low} + (NW + 1)'(idx);
  assign n_val   = n_sum[NW-1:0];
  assign p_pow2  = ((p & (p - 1'b1)) == '0) && (p != '0);
  assign addr    = idx[stdc_pkg::ADDR_W-1:0];

  always_comb begin
    case (cmd.div_sel)
      stdc_pkg::SEL_LOW_P: begin div_a = range_low; div_b = NW'(p); end
      stdc_pkg::SEL_R_P:   begin div_a = r;         div_b = NW'(p); end
      stdc_pkg::SEL_T_P:   begin div_a = t;         div_b = NW'(p); end
      stdc_pkg::SEL_T_R:   begin div_a = t;         div_b = r;      end
      stdc_pkg::SEL_T_DVS: begin div_a = t;         div_b = NW'(divisor); end
      default:             begin div_a = t;         div_b = NW'(p); end
    endcase
  end

  stdc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.div_go),
    .a    (div_a),
    .b    (div_b),
    .quo  (div_q),
    .rem  (div_r),
    .done (div_done)
  );

  always_comb begin
    we      = cmd.fill_wr | cmd.sieve_wr | cmd.fin_wr;
    tot_wd  = n_val;
    rest_wd = n_val;
    if (cmd.sieve_wr) begin
      tot_wd  = t - div_q;
      rest_wd = r;
    end else if (cmd.fin_wr) begin
      tot_wd  = t;
      rest_wd = NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tot_mem[addr]  <= tot_wd;
      rest_mem[addr] <= rest_wd;
    end
    tot_rd  <= tot_mem[addr];
    rest_rd <= rest_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.fill_wr || cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end else if (cmd.idx_step_p) begin
      idx <= idx + IW'(p);
    end else if (cmd.idx_from_rem) begin
      idx <= (div_r == '0) ? '0 : IW'(NW'(p) - div_r);
    end
    if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
    if (cmd.p_load) begin
      p <= prime_value;
    end
    if (cmd.sq_load) begin
      sq <= NW'(p * p);
    end
    if (cmd.rt_load) begin
      r <= rest_rd;
      t <= tot_rd;
    end else begin
      if (cmd.r_from_q) begin
        r <= div_q;
      end
      if (cmd.t_sub_q) begin
        t <= t - div_q;
      end
    end
  end

  always_comb begin
    stat.len_zero  = len_eff == '0;
    stat.idx_last  = (idx + 1'b1) == IW'(len_eff);
    stat.sieve_ok  = (p >= PW'(2)) && (len_eff != '0) && (sq <= top);
    stat.walk_end  = idx >= IW'(len_eff);
    stat.walk_skip = (n_val <= NW'(p)) || (n_sum[NW] && !p_pow2);
    stat.div_done  = div_done;
    stat.rem_zero  = div_r == '0;
    stat.r_zero    = r == '0;
    stat.r_gt1     = r > NW'(1);
    stat.dvs_zero  = divisor == '0;
  end

  assign divisible_count = cnt;
  assign window_count    = len_eff;

endmodule

>>> sv/stdc_ctrl.sv
module stdc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         command,
  input  stdc_pkg::dp_stat_t stat,
  output stdc_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               done
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_FILL  = 5'd1;
  localparam logic [4:0] S_SQ    = 5'd2;
  localparam logic [4:0] S_CHK   = 5'd3;
  localparam logic [4:0] S_MODW  = 5'd4;
  localparam logic [4:0] S_WALK  = 5'd5;
  localparam logic [4:0] S_SRD   = 5'd6;
  localparam logic [4:0] S_RDIV  = 5'd7;
  localparam logic [4:0] S_RWAIT = 5'd8;
  localparam logic [4:0] S_TWAIT = 5'd9;
  localparam logic [4:0] S_FRD   = 5'd10;
  localparam logic [4:0] S_FLD   = 5'd11;
  localparam logic [4:0] S_FCHK  = 5'd12;
  localparam logic [4:0] S_FPW   = 5'd13;
  localparam logic [4:0] S_FCNT  = 5'd14;
  localparam logic [4:0] S_FDW   = 5'd15;
  localparam logic [4:0] S_FNXT  = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (command)
            stdc_pkg::CMD_START: begin
              cmd.idx_clr = 1'b1;
              state_next  = stat.len_zero ? S_IDLE : S_FILL;
            end
            stdc_pkg::CMD_SIEVE: begin
              cmd.p_load = 1'b1;
              state_next = S_SQ;
            end
            stdc_pkg::CMD_FINISH: begin
              cmd.idx_clr = 1'b1;
              cmd.cnt_clr = 1'b1;
              state_next  = stat.len_zero ? S_DONE : S_FRD;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (stat.idx_last) begin
          state_next = S_IDLE;
        end
      end
      S_SQ: begin
        cmd.sq_load = 1'b1;
        state_next  = S_CHK;
      end
      S_CHK: begin
        if (stat.sieve_ok) begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = stdc_pkg::SEL_LOW_P;
          state_next  = S_MODW;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MODW: begin
        if (stat.div_done) begin
          cmd.idx_from_rem = 1'b1;
          state_next       = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.walk_end) begin
          state_next = S_IDLE;
        end else if (stat.walk_skip) begin
          cmd.idx_step_p = 1'b1;
        end else begin
          state_next = S_SRD;
        end
      end
      S_SRD: begin
        cmd.rt_load = 1'b1;
        state_next  = S_RDIV;
      end
      S_RDIV: begin
        cmd.div_go = 1'b1;
        if (stat.r_zero) begin
          cmd.div_sel = stdc_pkg::SEL_T_P;
          state_next  = S_TWAIT;
        end else begin
          cmd.div_sel = stdc_pkg::SEL_R_P;
          state_next  = S_RWAIT;
        end
      end
      S_RWAIT: begin
        if (stat.div_done) begin
          if (stat.rem_zero) begin
            cmd.r_from_q = 1'b1;
            state_next   = S_RDIV;
          end else begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = stdc_pkg::SEL_T_P;
            state_next  = S_TWAIT;
          end
        end
      end
      S_TWAIT: begin
        if (stat.div_done) begin
          cmd.sieve_wr   = 1'b1;
          cmd.idx_step_p = 1'b1;
          state_next     = S_WALK;
        end
      end
      S_FRD: state_next = S_FLD;
      S_FLD: begin
        cmd.rt_load = 1'b1;
        state_next  = S_FCHK;
      end
      S_FCHK: begin
        if (stat.r_gt1) begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = stdc_pkg::SEL_T_R;
          state_next  = S_FPW;
        end else begin
          state_next = S_FCNT;
        end
      end
      S_FPW: begin
        if (stat.div_done) begin
          cmd.t_sub_q = 1'b1;
          state_next  = S_FCNT;
        end
      end
      S_FCNT: begin
        cmd.fin_wr = 1'b1;
        if (stat.dvs_zero) begin
          state_next = S_FNXT;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = stdc_pkg::SEL_T_DVS;
          state_next  = S_FDW;
        end
      end
      S_FDW: begin
        if (stat.div_done) begin
          cmd.cnt_inc = stat.rem_zero;
          state_next  = S_FNXT;
        end
      end
      S_FNXT: begin
        if (stat.idx_last) begin
          state_next = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_FRD;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == S_MODW || state == S_RWAIT || state == S_TWAIT ||
                       state == S_FPW || state == S_FDW))
    else $error("divider finished outside a wait state");
  a_sieve_busy: assert property (@(posedge clk) disable iff (rst)
    accept && command == stdc_pkg::CMD_SIEVE |=> busy)
    else $error("sieve command not taken");
  a_one_wr: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.fill_wr, cmd.sieve_wr, cmd.fin_wr}))
    else $error("store write conflict");

endmodule
